@@ design/assert_macros.svh @@
// Shared assertion helpers for the graph6 decoder.
// AST_CHK checks a clocked property outside reset.
// AST_NEVER checks that an expression is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define AST_CHK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AST_NEVER(lbl, clk, rst_n, expr, msg) \
	`AST_CHK(lbl, clk, rst_n, !(expr), msg)
`endif

@@ design/gad_pkg.sv @@
`default_nettype none
package gad_pkg;
	// Field widths and defaults.
	localparam int VC_W          = 18;
	localparam int MAX_VERTS_DEF = 64;
	localparam int QDEPTH        = 4;

	// Printable graph6 range and the long header mark.
	localparam logic [7:0] BYTE_LO = 8'd63;
	localparam logic [7:0] BYTE_HI = 8'd126;
	localparam logic [7:0] TILDE   = 8'd126;

	// Result kinds on the output channel.
	localparam logic [1:0] KIND_COUNT = 2'd0;
	localparam logic [1:0] KIND_EDGE  = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Work items passed from the front end to the walker.
	typedef enum logic [1:0] {
		ENT_COUNT,
		ENT_ERROR,
		ENT_DATA,
		ENT_BAD
	} ent_kind_t;

	typedef struct packed {
		ent_kind_t        kind;
		logic [VC_W-1:0]  data;
	} gad_ent_t;
endpackage
`default_nettype wire

@@ design/graph6_adjacency_decoder.sv @@
// graph6 adjacency decoder.
// Input channel: one character of graph6 text per beat on data_byte, with
// start_flag set on the first character of each string. byte_stall rises only
// when the four-entry work queue is full; otherwise a beat is taken every cycle.
// Output channel: one result per beat: a vertex count, an edge (row above col)
// or an error, with last marking the final result caused by one input byte.
// A count or error item passes through the work queue and then the result
// register before it is presented; an edge also passes through the walker.
// Count and error items leave the queue at one per cycle while the result
// register is free. The edge walker loads a data byte's triangle mask when
// it pops the byte and then steps through its six bits, taking no new byte
// until the last bit is done; it gives at most one edge per cycle.
// Reset clears the parser, the queue and the output register; bytes before
// the first start flag are dropped. When res_stall is high the result register
// holds its beat, the walker waits and the queue fills, and after that
// byte_stall holds off the sender. No result is lost or repeated.
`default_nettype none
module graph6_adjacency_decoder #(
	parameter int MAX_VERTS = gad_pkg::MAX_VERTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  logic [7:0]               data_byte,
	input  logic                     start_flag,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [1:0]               kind,
	output logic [gad_pkg::VC_W-1:0] vertex_count,
	output logic [5:0]               row,
	output logic [5:0]               col,
	output logic                     last
);
	import gad_pkg::*;

	logic     q_full, q_empty, q_push, q_pop;
	gad_ent_t push_ent, pop_ent;

	assign byte_stall = q_full;

	// Header parser and byte classifier.
	gad_front #(.MAX_VERTS(MAX_VERTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.q_full     (q_full),
		.data_byte  (data_byte),
		.start_flag (start_flag),
		.push       (q_push),
		.push_ent   (push_ent)
	);

	// Work queue between parser and walker.
	gad_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (push_ent),
		.full     (q_full),
		.pop      (q_pop),
		.pop_ent  (pop_ent),
		.empty    (q_empty)
	);

	// Triangle walker and result register.
	gad_back #(.MAX_VERTS(MAX_VERTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_ent        (pop_ent),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.vertex_count (vertex_count),
		.row          (row),
		.col          (col),
		.last         (last)
	);
endmodule
`default_nettype wire

@@ design/gad_front.sv @@
`default_nettype none
module gad_front #(
	parameter int MAX_VERTS = gad_pkg::MAX_VERTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              q_full,
	input  logic [7:0]        data_byte,
	input  logic              start_flag,
	output logic              push,
	output gad_pkg::gad_ent_t push_ent
);
	import gad_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_HDR0 = 6'b000010,
		ST_HDR1 = 6'b000100,
		ST_HDR2 = 6'b001000,
		ST_HDR3 = 6'b010000,
		ST_DATA = 6'b100000
	} fst_t;

	fst_t            state_q, state_d, eff_state;
	logic [VC_W-1:0] acc_q, acc_d;
	logic [VC_W-1:0] n_cand;
	logic            count_hit;
	logic            accept;
	logic            bad;
	logic [5:0]      v6;

	assign accept = byte_valid && !q_full;
	assign bad    = (data_byte < BYTE_LO) || (data_byte > BYTE_HI);
	assign v6     = 6'(data_byte - BYTE_LO);

	// Header parsing and classification of each accepted beat.
	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		push      = 1'b0;
		push_ent  = '{kind: ENT_DATA, data: '0};
		n_cand    = '0;
		count_hit = 1'b0;
		eff_state = start_flag ? ST_HDR0 : state_q;
		if (accept) begin
			state_d = eff_state;
			if (eff_state != ST_IDLE && bad) begin
				push = 1'b1;
				push_ent.kind = (eff_state == ST_DATA) ? ENT_BAD : ENT_ERROR;
				state_d = ST_IDLE;
			end else begin
				case (eff_state)
					ST_IDLE: begin
					end
					ST_HDR0: begin
						if (data_byte == TILDE) begin
							acc_d   = '0;
							state_d = ST_HDR1;
						end else begin
							n_cand    = {12'b0, v6};
							count_hit = 1'b1;
						end
					end
					ST_HDR1: begin
						if (data_byte == TILDE) begin
							push          = 1'b1;
							push_ent.kind = ENT_ERROR;
							state_d       = ST_IDLE;
						end else begin
							acc_d   = {12'b0, v6};
							state_d = ST_HDR2;
						end
					end
					ST_HDR2: begin
						acc_d   = {acc_q[VC_W-7:0], v6};
						state_d = ST_HDR3;
					end
					ST_HDR3: begin
						n_cand    = {acc_q[VC_W-7:0], v6};
						count_hit = 1'b1;
					end
					ST_DATA: begin
						push          = 1'b1;
						push_ent.kind = ENT_DATA;
						push_ent.data = {12'b0, v6};
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			// A complete header either reports the count or fails the size check.
			if (count_hit) begin
				push = 1'b1;
				if (n_cand > VC_W'(MAX_VERTS)) begin
					push_ent.kind = ENT_ERROR;
					state_d       = ST_IDLE;
				end else begin
					push_ent.kind = ENT_COUNT;
					push_ent.data = n_cand;
					state_d       = (n_cand < VC_W'(2)) ? ST_IDLE : ST_DATA;
				end
			end
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
		end
	end
endmodule
`default_nettype wire

@@ design/gad_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"
module gad_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gad_pkg::gad_ent_t push_ent,
	output logic              full,
	input  logic              pop,
	output gad_pkg::gad_ent_t pop_ent,
	output logic              empty
);
	import gad_pkg::*;

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	gad_ent_t        ent_q [QDEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full    = (cnt_q == CW'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_ent = ent_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_ent;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	`AST_NEVER(a_fifo_overflow, clk, arst_n, push && full && !pop, "queue written while full")
	`AST_NEVER(a_fifo_underflow, clk, arst_n, pop && empty, "queue read while empty")
endmodule
`default_nettype wire

@@ design/gad_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module gad_back #(
	parameter int MAX_VERTS = gad_pkg::MAX_VERTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  gad_pkg::gad_ent_t        q_ent,
	output logic                     q_pop,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [1:0]               kind,
	output logic [gad_pkg::VC_W-1:0] vertex_count,
	output logic [5:0]               row,
	output logic [5:0]               col,
	output logic                     last
);
	import gad_pkg::*;

	localparam int RW = $clog2(MAX_VERTS + 1);
	localparam int SW = RW + 2;

	// Walk state.
	logic [RW-1:0] n_q, row_q, col_q;
	logic          done_q, busy_q;
	logic [2:0]    bit_q;
	logic [5:0]    v_q, in_q;

	// Output register.
	logic            res_valid_q;
	logic [1:0]      rkind_q;
	logic [VC_W-1:0] rcount_q;
	logic [5:0]      rrow_q, rcol_q;
	logic            rlast_q;

	logic            out_free;
	logic [SW-1:0]   row_x, col_x, n_x, s0, t1, t2, t3, sum;
	logic [2:0]      slots, k;
	logic [5:0]      mask;
	logic            needs_out;
	logic            w_emit, w_ins, w_adv, w_last, wrap;
	logic            step_mid;
	logic [5:0]      low;
	logic [RW-1:0]   col_inc;
	logic [RW+5:0]   row_ext, col_ext;
	logic            ld;
	logic [1:0]      ld_kind;
	logic [VC_W-1:0] ld_count;
	logic [5:0]      ld_row, ld_col;
	logic            ld_last;

	assign out_free = !res_valid_q || !res_stall;

	// Triangle slots left from the current position, saturated at seven.
	// Four rows are needed: starting from row one, three rows hold only six slots.
	always_comb begin
		row_x = {2'b0, row_q};
		col_x = {2'b0, col_q};
		n_x   = {2'b0, n_q};
		s0    = row_x - col_x;
		t1    = row_x + SW'(1);
		t2    = row_x + SW'(2);
		t3    = row_x + SW'(3);
		sum   = s0 + ((t1 < n_x) ? t1 : '0) + ((t2 < n_x) ? t2 : '0)
			+ ((t3 < n_x) ? t3 : '0);
		slots = (sum >= SW'(7)) ? 3'd7 : sum[2:0];
		k     = (slots == 3'd7) ? 3'd6 : slots;
		for (int p = 0; p < 6; p++) begin
			mask[5-p] = (3'(p) < k);
		end
	end

	// Bit step of the walker.
	assign w_emit   = busy_q && v_q[bit_q];
	assign w_ins    = in_q[bit_q];
	assign w_adv    = busy_q && (!w_emit || out_free);
	assign step_mid = busy_q && w_adv && (bit_q != 3'd0);
	assign low      = 6'((7'd1 << bit_q) - 7'd1);
	assign w_last   = ((v_q & low) == 6'd0);
	assign col_inc  = col_q + RW'(1);
	assign wrap     = (col_inc >= row_q);
	assign row_ext  = {6'b0, row_q};
	assign col_ext  = {6'b0, col_q};

	// Queue pop and output load selection.
	always_comb begin
		case (q_ent.kind)
			ENT_COUNT: needs_out = 1'b1;
			ENT_ERROR: needs_out = 1'b1;
			ENT_BAD:   needs_out = !done_q;
			ENT_DATA:  needs_out = 1'b0;
			default:   needs_out = 1'b0;
		endcase
		q_pop    = !busy_q && !q_empty && (!needs_out || out_free);
		ld       = 1'b0;
		ld_kind  = KIND_COUNT;
		ld_count = '0;
		ld_row   = '0;
		ld_col   = '0;
		ld_last  = 1'b1;
		if (q_pop) begin
			case (q_ent.kind)
				ENT_COUNT: begin
					ld       = 1'b1;
					ld_count = q_ent.data;
				end
				ENT_ERROR: begin
					ld      = 1'b1;
					ld_kind = KIND_ERROR;
				end
				ENT_BAD: begin
					ld      = !done_q;
					ld_kind = KIND_ERROR;
				end
				default: begin
				end
			endcase
		end else if (w_adv && w_emit) begin
			ld      = 1'b1;
			ld_kind = KIND_EDGE;
			ld_row  = row_ext[5:0];
			ld_col  = col_ext[5:0];
			ld_last = w_last;
		end
	end

	// Walker control and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			row_q       <= RW'(1);
			col_q       <= '0;
			done_q      <= 1'b1;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_ent.kind)
					ENT_COUNT: begin
						n_q    <= q_ent.data[RW-1:0];
						row_q  <= RW'(1);
						col_q  <= '0;
						done_q <= (q_ent.data < VC_W'(2));
					end
					ENT_ERROR: begin
						done_q <= 1'b1;
					end
					ENT_BAD: begin
						done_q <= 1'b1;
					end
					ENT_DATA: begin
						if (!done_q) begin
							busy_q <= 1'b1;
							done_q <= (slots != 3'd7);
						end
					end
					default: begin
					end
				endcase
			end else if (w_adv) begin
				if (w_ins) begin
					if (wrap) begin
						row_q <= row_q + RW'(1);
						col_q <= '0;
					end else begin
						col_q <= col_inc;
					end
				end
				if (bit_q == 3'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Walk payload: the masked data bits and the bit position.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			bit_q <= 3'd5;
			v_q   <= q_ent.data[5:0] & mask;
			in_q  <= mask;
		end else if (w_adv && bit_q != 3'd0) begin
			bit_q <= bit_q - 3'd1;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (ld) begin
			rkind_q  <= ld_kind;
			rcount_q <= ld_count;
			rrow_q   <= ld_row;
			rcol_q   <= ld_col;
			rlast_q  <= ld_last;
		end
	end

	assign res_valid    = res_valid_q;
	assign kind         = rkind_q;
	assign vertex_count = rcount_q;
	assign row          = rrow_q;
	assign col          = rcol_q;
	assign last         = rlast_q;

	`AST_CHK(a_walk_steps, clk, arst_n, step_mid |=> bit_q == $past(bit_q) - 3'd1, "walker skipped a bit")
	`AST_CHK(a_edge_order, clk, arst_n, w_emit |-> row_q > col_q, "edge column not below its row")
endmodule
`default_nettype wire
